### src/asgr_pkg.sv
// Types, codes and helpers shared by the SGR color parser.
`default_nettype none
package asgr_pkg;

	// Position in the grammar "[0m", "[0;FGm", "[0;FG;BGm".
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_MODE = 4'd1,
		PH_SEP1 = 4'd2,
		PH_FG1  = 4'd3,
		PH_FG2  = 4'd4,
		PH_SEP2 = 4'd5,
		PH_BG1  = 4'd6,
		PH_BG1B = 4'd7,
		PH_BG2  = 4'd8,
		PH_END  = 4'd9
	} asgr_phase_t;

	// Register indexes of the write port.
	localparam logic REG_DEFAULT_ATTR = 1'b0;
	localparam logic REG_COLOR_TABLE  = 1'b1;

	localparam logic [7:0]  DEFAULT_ATTR_RST = 8'h07;
	localparam logic [23:0] COLOR_TABLE_RST  = 24'hEE9CA0;

	// Characters of the grammar.
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_3      = 8'h33;
	localparam logic [7:0] CH_4      = 8'h34;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;

	// Table digits used by the zero codes.
	localparam logic [2:0] FG_ZERO_DIGIT = 3'd7;
	localparam logic [2:0] BG_ZERO_DIGIT = 3'd0;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// One result of the parser core.
	typedef struct packed {
		logic       fire;
		logic [7:0] attribute;
		logic       status;
		logic [3:0] consumed;
	} asgr_res_t;

	// Pick the 3-bit VGA color of an ANSI base digit.
	function automatic logic [2:0] table_color(input logic [23:0] tbl, input logic [2:0] digit);
		logic [23:0] sh;
		sh = tbl >> ({2'b00, digit} * 5'd3);
		return sh[2:0];
	endfunction

endpackage
`default_nettype wire

### src/asgr_if.sv
// Valid/ready channels for escape bytes in and attribute results out.
`default_nettype none
interface asgr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       seq_start;

	modport source (output valid, output ch, output seq_start, input ready);
	modport sink   (input valid, input ch, input seq_start, output ready);
endinterface

interface asgr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] attribute;
	logic       status;
	logic [3:0] consumed;

	modport source (output valid, output attribute, output status, output consumed,
		input ready);
	modport sink   (input valid, input attribute, input status, input consumed,
		output ready);
endinterface
`default_nettype wire

### src/asgr_fsm.sv
// Grammar state machine: consumes one byte per step and forms the result.
`default_nettype none
module asgr_fsm
	import asgr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  ch,
	input  wire logic        seq_start,
	input  wire logic [7:0]  default_attr,
	input  wire logic [23:0] color_table,
	output asgr_res_t        res
);

	asgr_phase_t phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [2:0]  fg_dig_q, fg_dig_d, bg_dig_q, bg_dig_d;
	logic        fg_brt_q, fg_brt_d, bg_brt_q, bg_brt_d;
	logic        fg_zero_q, fg_zero_d, bg_zero_q, bg_zero_d;
	logic        is_digit07;
	logic [3:0]  fg_nib, bg_nib;

	assign is_digit07 = (ch >= CH_0) && (ch <= CH_7);

	assign fg_nib = fg_zero_q ? {1'b0, table_color(color_table, FG_ZERO_DIGIT)}
		: {fg_brt_q, table_color(color_table, fg_dig_q)};
	assign bg_nib = bg_zero_q ? {1'b0, table_color(color_table, BG_ZERO_DIGIT)}
		: {bg_brt_q, table_color(color_table, bg_dig_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			fg_dig_q  <= '0;
			fg_brt_q  <= 1'b0;
			fg_zero_q <= 1'b1;
			bg_dig_q  <= '0;
			bg_brt_q  <= 1'b0;
			bg_zero_q <= 1'b1;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			fg_dig_q  <= fg_dig_d;
			fg_brt_q  <= fg_brt_d;
			fg_zero_q <= fg_zero_d;
			bg_dig_q  <= bg_dig_d;
			bg_brt_q  <= bg_brt_d;
			bg_zero_q <= bg_zero_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		fg_dig_d  = fg_dig_q;
		fg_brt_d  = fg_brt_q;
		fg_zero_d = fg_zero_q;
		bg_dig_d  = bg_dig_q;
		bg_brt_d  = bg_brt_q;
		bg_zero_d = bg_zero_q;
		res       = '{fire: 1'b0, attribute: 8'h00, status: STATUS_REJECT,
			consumed: count_q};

		if (seq_start) begin
			// Start over: drop any open sequence without a result.
			count_d      = 4'd1;
			fg_dig_d     = '0;
			fg_brt_d     = 1'b0;
			fg_zero_d    = 1'b1;
			bg_dig_d     = '0;
			bg_brt_d     = 1'b0;
			bg_zero_d    = 1'b1;
			res.consumed = 4'd1;
			if (ch != CH_LBRACK) begin
				res.fire = 1'b1;
				phase_d  = PH_IDLE;
			end else begin
				phase_d = PH_MODE;
			end
		end else if (phase_q != PH_IDLE) begin
			count_d      = count_q + 4'd1;
			res.consumed = count_d;
			// Reject unless an arm below moves on or accepts.
			res.fire     = 1'b1;
			phase_d      = PH_IDLE;
			unique case (phase_q)
				PH_MODE: begin
					if (ch == CH_0) begin
						res.fire = 1'b0;
						phase_d  = PH_SEP1;
					end
				end
				PH_SEP1: begin
					if (ch == CH_M) begin
						res.attribute = default_attr;
						res.status    = STATUS_OK;
					end else if (ch == CH_SEMI) begin
						res.fire = 1'b0;
						phase_d  = PH_FG1;
					end
				end
				PH_FG1: begin
					if (ch == CH_0) begin
						res.fire  = 1'b0;
						fg_zero_d = 1'b1;
						phase_d   = PH_SEP2;
					end else if (ch == CH_3 || ch == CH_9) begin
						res.fire  = 1'b0;
						fg_zero_d = 1'b0;
						fg_brt_d  = (ch == CH_9);
						phase_d   = PH_FG2;
					end
				end
				PH_FG2: begin
					if (is_digit07) begin
						res.fire = 1'b0;
						fg_dig_d = ch[2:0];
						phase_d  = PH_SEP2;
					end
				end
				PH_SEP2: begin
					if (ch == CH_M) begin
						res.attribute = {default_attr[7:4], fg_nib};
						res.status    = STATUS_OK;
					end else if (ch == CH_SEMI) begin
						res.fire = 1'b0;
						phase_d  = PH_BG1;
					end
				end
				PH_BG1: begin
					if (ch == CH_0) begin
						res.fire  = 1'b0;
						bg_zero_d = 1'b1;
						phase_d   = PH_END;
					end else if (ch == CH_4) begin
						res.fire  = 1'b0;
						bg_zero_d = 1'b0;
						bg_brt_d  = 1'b0;
						phase_d   = PH_BG2;
					end else if (ch == CH_1) begin
						res.fire = 1'b0;
						phase_d  = PH_BG1B;
					end
				end
				PH_BG1B: begin
					if (ch == CH_0) begin
						res.fire  = 1'b0;
						bg_zero_d = 1'b0;
						bg_brt_d  = 1'b1;
						phase_d   = PH_BG2;
					end
				end
				PH_BG2: begin
					if (is_digit07) begin
						res.fire = 1'b0;
						bg_dig_d = ch[2:0];
						phase_d  = PH_END;
					end
				end
				PH_END: begin
					if (ch == CH_M) begin
						res.attribute = {bg_nib, fg_nib};
						res.status    = STATUS_OK;
					end
				end
				default: begin
					// Unused codes behave as idle.
					res.fire = 1'b0;
					count_d  = count_q;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.fire) |=> (phase_q == PH_IDLE))
		else $error("phase not idle after a result");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.fire && res.status == STATUS_REJECT) |-> (res.attribute == 8'h00))
		else $error("rejected sequence carries an attribute");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |-> (res.consumed != 4'd0 && res.consumed <= 4'd10))
		else $error("consumed count out of range");
`endif

endmodule
`default_nettype wire

### src/ansi_sgr_color_parser_top.sv
// Top level of the SGR color escape parser with its input and result registers.
//
// The parser takes the bytes that follow an ESC, one byte per item on the seq
// channel, and checks them against "[0m", "[0;FGm" and "[0;FG;BGm" (FG is 0,
// 30-37 or 90-97, BG is 0, 40-47 or 100-107; 9x and 10x set the bright bit).
// Each sequence not abandoned gives exactly one item on attr: status 0 with
// the VGA attribute byte (fg in bits 3:0, bg in bits 7:4), or status 1 with a
// zero attribute at the first bad byte; consumed counts bytes from the
// bracket through the final byte. Bytes outside an open sequence give
// nothing; seq_start abandons any open sequence. Throughput is one byte per
// clock unless a finished result waits on a stalled attr channel while the
// byte in the input register would produce another one. Each byte passes an
// input register, the grammar logic and a result register that offers its
// result on attr. default_attribute (index 0) and color_table (index 1,
// entry i in bits 3i+2:3i) are written through wr_en/wr_index/wr_data; the
// user must write them only while the block idles, which the block itself
// does not enforce.
`default_nettype none
module ansi_sgr_color_parser_top
	import asgr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire logic  wr_index,
	input  wire logic [23:0] wr_data,
	asgr_in_if.sink    seq,
	asgr_out_if.source attr
);

	logic [7:0]  default_attr_q;
	logic [23:0] color_table_q;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        start_s1;

	logic        out_valid_q;
	logic [7:0]  attribute_q;
	logic        status_q;
	logic [3:0]  consumed_q;

	asgr_res_t   res;
	logic        out_free;
	logic        go_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEFAULT_ATTR_RST;
			color_table_q  <= COLOR_TABLE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEFAULT_ATTR: default_attr_q <= wr_data[7:0];
				REG_COLOR_TABLE:  color_table_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// Advance the stage-1 item unless it makes a result and the result
	// register is still full.
	assign out_free  = !out_valid_q || attr.ready;
	assign go_s1     = valid_s1 && (!res.fire || out_free);
	assign seq.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seq.ready) begin
			valid_s1 <= seq.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.valid && seq.ready) begin
			ch_s1    <= seq.ch;
			start_s1 <= seq.seq_start;
		end
	end

	asgr_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (go_s1),
		.ch           (ch_s1),
		.seq_start    (start_s1),
		.default_attr (default_attr_q),
		.color_table  (color_table_q),
		.res          (res)
	);

	// Result register: load on a result, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (attr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res.fire) begin
			attribute_q <= res.attribute;
			status_q    <= res.status;
			consumed_q  <= res.consumed;
		end
	end

	assign attr.valid     = out_valid_q;
	assign attr.attribute = attribute_q;
	assign attr.status    = status_q;
	assign attr.consumed  = consumed_q;

`ifndef SYNTH
	a_stalled_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(ch_s1) && $stable(start_s1)))
		else $error("stage-1 item lost while stalled");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !attr.ready) |-> !(go_s1 && res.fire))
		else $error("result register overwritten while full");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the SGR color escape parser top level.
`default_nettype none
module tb_top;
	import asgr_pkg::*;

	// Bench timing: a result leaves via the input and result registers, so a
	// short settle window covers the pipeline once every expected item is back.
	localparam int HALF_PERIOD  = 4;
	localparam int SETTLE_CYC   = 10;
	localparam int WD_LIMIT     = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_QUOTA  = 285;
	localparam int NUM_PHASES   = 6;
	localparam int PRINT_CAP    = 40;

	// Entry i holds color i: every table slot is distinguishable on the output.
	localparam logic [23:0] IDENTITY_TABLE = 24'hFAC688;

	// Bytes that sit close to the grammar, used to build near misses.
	localparam logic [7:0] GRAMMAR_CHARS [10] = '{CH_LBRACK, CH_SEMI, CH_M, CH_0, CH_1,
		CH_3, CH_4, CH_7, CH_7 + 8'd1, CH_9};

	typedef struct packed {
		logic [7:0] ch;
		logic       start;
	} esc_byte_t;

	typedef struct packed {
		logic [7:0] attribute;
		logic       status;
		logic [3:0] consumed;
	} sgr_result_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [23:0] wr_data;

	asgr_in_if  seq_ch ();
	asgr_out_if attr_ch ();

	ansi_sgr_color_parser_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.seq     (seq_ch.sink),
		.attr    (attr_ch.source)
	);

	// Bytes waiting to be offered, and attribute results waiting to arrive.
	esc_byte_t   esc_bytes_q[$];
	sgr_result_t pending_attr_q[$];

	// Shadow of the parser: grammar position, gathered codes, byte count and
	// the two configuration registers.
	asgr_phase_t pst;
	logic [6:0]  fg_acc;
	logic [6:0]  bg_acc;
	logic [3:0]  nbytes;
	logic [7:0]  cfg_attr;
	logic [23:0] cfg_table;

	// Idling knobs, set per phase by the stimulus process.
	int src_idle_pct;
	int sink_stall_pct;
	bit pressure_go;
	bit pressure_done;
	int hold_left;

	logic in_took;
	int   wd_count;
	int   n_errors;
	int   n_bytes;
	int   n_ok;
	int   n_rej;
	int   n_queued;

	always #(HALF_PERIOD) clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Look up the 4-bit nibble of an FG or BG code; bright codes set bit 3.
	function automatic logic [3:0] color_nibble(input logic [6:0] code, input logic [6:0] base,
		input logic [6:0] bright_base, input logic [2:0] zero_digit);
		logic [6:0] off;
		if (code == 7'd0) begin
			return {1'b0, cfg_table[3 * zero_digit +: 3]};
		end
		if (code >= bright_base) begin
			off = code - bright_base;
			return {1'b1, cfg_table[3 * off[2:0] +: 3]};
		end
		off = code - base;
		return {1'b0, cfg_table[3 * off[2:0] +: 3]};
	endfunction

	// Advance the shadow parser by one byte; return 1 when it closes a sequence.
	function automatic bit sgr_step(input logic [7:0] c, input logic start,
		output sgr_result_t res);
		bit         done;
		bit         dig07;
		logic [7:0] a;
		logic       s;
		logic [3:0] fgn;
		logic [3:0] bgn;
		done  = 1'b0;
		a     = 8'd0;
		s     = STATUS_REJECT;
		res   = '0;
		dig07 = (c >= CH_0) && (c <= CH_7);
		if (start) begin
			// A start byte abandons whatever was open.
			fg_acc = 7'd0;
			bg_acc = 7'd0;
			nbytes = 4'd1;
			if (c != CH_LBRACK) begin
				done = 1'b1;
			end else begin
				pst = PH_MODE;
			end
		end else if (pst != PH_IDLE) begin
			nbytes = nbytes + 4'd1;
			case (pst)
				PH_MODE: begin
					if (c != CH_0) done = 1'b1;
					else pst = PH_SEP1;
				end
				PH_SEP1: begin
					if (c == CH_M) begin
						done = 1'b1;
						a    = cfg_attr;
						s    = STATUS_OK;
					end else if (c != CH_SEMI) begin
						done = 1'b1;
					end else begin
						pst = PH_FG1;
					end
				end
				PH_FG1: begin
					if (c == CH_0) begin
						fg_acc = 7'd0;
						pst    = PH_SEP2;
					end else if (c == CH_3) begin
						fg_acc = 7'd30;
						pst    = PH_FG2;
					end else if (c == CH_9) begin
						fg_acc = 7'd90;
						pst    = PH_FG2;
					end else begin
						done = 1'b1;
					end
				end
				PH_FG2: begin
					if (!dig07) begin
						done = 1'b1;
					end else begin
						fg_acc = fg_acc + 7'(c - CH_0);
						pst    = PH_SEP2;
					end
				end
				PH_SEP2: begin
					if (c == CH_M) begin
						fgn  = color_nibble(fg_acc, 7'd30, 7'd90, FG_ZERO_DIGIT);
						done = 1'b1;
						a    = {cfg_attr[7:4], fgn};
						s    = STATUS_OK;
					end else if (c != CH_SEMI) begin
						done = 1'b1;
					end else begin
						pst = PH_BG1;
					end
				end
				PH_BG1: begin
					if (c == CH_0) begin
						bg_acc = 7'd0;
						pst    = PH_END;
					end else if (c == CH_4) begin
						bg_acc = 7'd40;
						pst    = PH_BG2;
					end else if (c == CH_1) begin
						pst = PH_BG1B;
					end else begin
						done = 1'b1;
					end
				end
				PH_BG1B: begin
					if (c != CH_0) begin
						done = 1'b1;
					end else begin
						bg_acc = 7'd100;
						pst    = PH_BG2;
					end
				end
				PH_BG2: begin
					if (!dig07) begin
						done = 1'b1;
					end else begin
						bg_acc = bg_acc + 7'(c - CH_0);
						pst    = PH_END;
					end
				end
				default: begin
					done = 1'b1;
					if (c == CH_M) begin
						fgn = color_nibble(fg_acc, 7'd30, 7'd90, FG_ZERO_DIGIT);
						bgn = color_nibble(bg_acc, 7'd40, 7'd100, BG_ZERO_DIGIT);
						a   = {bgn, fgn};
						s   = STATUS_OK;
					end
				end
			endcase
		end
		if (done) begin
			res.attribute = a;
			res.status    = s;
			res.consumed  = nbytes;
			pst           = PH_IDLE;
		end
		return done;
	endfunction

	// ------------------------------------------------------------------ helpers

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Queue one byte; counted ones drive the per-phase quota.
	task automatic push_item(input logic [7:0] c, input logic start, input bit counted);
		esc_bytes_q.push_back('{ch: c, start: start});
		if (counted) n_queued++;
	endtask

	// Queue a whole text as one sequence: the first byte opens it.
	task automatic push_text(input string txt);
		for (int i = 0; i < txt.len(); i++) push_item(txt[i], i == 0, 1'b1);
	endtask

	function automatic logic [7:0] junk_char();
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return GRAMMAR_CHARS[$urandom_range(9)];
	endfunction

	// Build one random sequence. Most are well formed with random colors; the
	// rest get a bad byte, are cut short and abandoned, or are plain noise.
	task automatic gen_sequence();
		logic [7:0] body[$];
		int         kind;
		int         form;
		int         pos;
		logic [7:0] d;
		kind = $urandom_range(99);
		if (kind >= 93) begin
			repeat ($urandom_range(4, 1)) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
			if ($urandom_range(1)) push_item(8'($urandom_range(255)), 1'b1, 1'b1);
			return;
		end
		body = '{CH_LBRACK, CH_0};
		form = $urandom_range(2);
		if (form == 0) begin
			body.push_back(CH_M);
		end else begin
			body.push_back(CH_SEMI);
			d = 8'($urandom_range(7));
			case ($urandom_range(2))
				0: body.push_back(CH_0);
				1: begin
					body.push_back(CH_3);
					body.push_back(CH_0 + d);
				end
				default: begin
					body.push_back(CH_9);
					body.push_back(CH_0 + d);
				end
			endcase
			if (form == 2) begin
				body.push_back(CH_SEMI);
				d = 8'($urandom_range(7));
				case ($urandom_range(2))
					0: body.push_back(CH_0);
					1: begin
						body.push_back(CH_4);
						body.push_back(CH_0 + d);
					end
					default: begin
						body.push_back(CH_1);
						body.push_back(CH_0);
						body.push_back(CH_0 + d);
					end
				endcase
			end
			body.push_back(CH_M);
		end
		if (kind >= 70 && kind < 85) begin
			pos       = $urandom_range(body.size() - 1);
			body[pos] = junk_char();
		end else if (kind >= 85) begin
			// Leave it open; the next start byte abandons it.
			body = body[0 : $urandom_range(body.size() - 2)];
		end
		foreach (body[i]) push_item(body[i], i == 0, 1'b1);
		if ($urandom_range(9) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
	endtask

	// Write one register and mirror it into the shadow copy.
	task automatic write_reg(input logic idx, input logic [23:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		if (idx == REG_DEFAULT_ATTR) cfg_attr = val[7:0];
		else cfg_table = val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Hold until every byte is taken and every result is back, then let the
	// pipeline settle so a byte with no result cannot still be in flight.
	task automatic wait_drained();
		do @(posedge clk);
		while (esc_bytes_q.size() != 0 || seq_ch.valid || pending_attr_q.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// ------------------------------------------------------------------- driver

	// Offer a new byte once the previous one was taken or nothing is on the
	// channel; skip offering at random per the current idle rate.
	always @(negedge clk) begin
		if (!seq_ch.valid || in_took) begin
			if (esc_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				seq_ch.valid     <= 1'b1;
				seq_ch.ch        <= esc_bytes_q[0].ch;
				seq_ch.seq_start <= esc_bytes_q[0].start;
				void'(esc_bytes_q.pop_front());
			end else begin
				seq_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: stall at random, or hold ready low for a long stretch once
	// to let the block back up and stop taking bytes.
	always @(negedge clk) begin
		if (pressure_go && !pressure_done) begin
			hold_left     = HOLD_CYCLES;
			pressure_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			attr_ch.ready <= 1'b0;
		end else begin
			attr_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------ monitor

	// Check the result first: nothing taken at this edge can produce it.
	always @(posedge clk) begin
		sgr_result_t want;
		sgr_result_t res;
		in_took <= seq_ch.valid && seq_ch.ready;
		if (attr_ch.valid && attr_ch.ready) begin
			if (attr_ch.status === STATUS_OK) n_ok++;
			else n_rej++;
			if (pending_attr_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result attr %02h status %0b consumed %0d",
					attr_ch.attribute, attr_ch.status, attr_ch.consumed));
			end else begin
				want = pending_attr_q.pop_front();
				if (attr_ch.attribute !== want.attribute)
					report_mismatch($sformatf("attribute got %02h want %02h",
						attr_ch.attribute, want.attribute));
				if (attr_ch.status !== want.status)
					report_mismatch($sformatf("status got %0b want %0b",
						attr_ch.status, want.status));
				if (attr_ch.consumed !== want.consumed)
					report_mismatch($sformatf("consumed got %0d want %0d",
						attr_ch.consumed, want.consumed));
			end
		end
		if (seq_ch.valid && seq_ch.ready) begin
			n_bytes++;
			if (sgr_step(seq_ch.ch, seq_ch.seq_start, res)) pending_attr_q.push_back(res);
		end
	end

	// Watchdog: count cycles with work outstanding but no item moving.
	always @(posedge clk) begin
		if ((seq_ch.valid && seq_ch.ready) || (attr_ch.valid && attr_ch.ready) ||
			(esc_bytes_q.size() == 0 && !seq_ch.valid && pending_attr_q.size() == 0)) begin
			wd_count <= 0;
		end else begin
			wd_count <= wd_count + 1;
		end
		if (wd_count >= WD_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", wd_count);
			$display("ansi_sgr_color_parser_top verification failed");
			$finish;
		end
	end

	// ----------------------------------------------------------------- stimulus

	initial begin
		logic [7:0]  attr_val;
		logic [23:0] table_val;
		clk              = 1'b0;
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = REG_DEFAULT_ATTR;
		wr_data          = 24'd0;
		seq_ch.valid     = 1'b0;
		seq_ch.ch        = 8'd0;
		seq_ch.seq_start = 1'b0;
		attr_ch.ready    = 1'b0;
		in_took          = 1'b0;
		src_idle_pct     = 0;
		sink_stall_pct   = 0;
		pressure_go      = 1'b0;
		pressure_done    = 1'b0;
		hold_left        = 0;
		wd_count         = 0;
		n_errors         = 0;
		n_bytes          = 0;
		n_ok             = 0;
		n_rej            = 0;
		n_queued         = 0;
		pst              = PH_IDLE;
		fg_acc           = 7'd0;
		bg_acc           = 7'd0;
		nbytes           = 4'd0;
		cfg_attr         = DEFAULT_ATTR_RST;
		cfg_table        = COLOR_TABLE_RST;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on reset values: bare reset, full form with both zero
		// codes, the longest bright form, a bad start byte, a stray byte while
		// idle, and a sequence abandoned by a restart that is foreground only.
		push_text("[0m");
		push_text("[0;0;0m");
		push_text("[0;97;107m");
		push_item(8'hFF, 1'b1, 1'b1);
		push_item(8'h00, 1'b0, 1'b0);
		push_text("[0;");
		push_text("[0;37m");
		push_item(8'h00, 1'b1, 1'b1);
		wait_drained();

		for (int p = 1; p <= NUM_PHASES; p++) begin
			attr_val  = 8'($urandom_range(255));
			table_val = 24'($urandom_range(24'hFFFFFF));
			case (p)
				1: begin
					attr_val       = 8'hFF;
					table_val      = 24'h000000;
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				2: begin
					attr_val       = 8'h00;
					table_val      = 24'hFFFFFF;
					src_idle_pct   = 66;
					sink_stall_pct = 0;
				end
				3: begin
					src_idle_pct   = 0;
					sink_stall_pct = 66;
				end
				4: begin
					table_val      = IDENTITY_TABLE;
					src_idle_pct   = 31;
					sink_stall_pct = 31;
				end
				5: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				default: begin
					attr_val       = DEFAULT_ATTR_RST;
					table_val      = COLOR_TABLE_RST;
					src_idle_pct   = 31;
					sink_stall_pct = 31;
				end
			endcase
			write_reg(REG_DEFAULT_ATTR, {16'd0, attr_val});
			write_reg(REG_COLOR_TABLE, table_val);
			@(posedge clk);
			if (p == 4) pressure_go = 1'b1;
			n_queued = 0;
			while (n_queued < PHASE_QUOTA) gen_sequence();
			// Close any open sequence so the next register write sees an idle parser.
			push_item(8'h00, 1'b1, 1'b1);
			wait_drained();
		end

		if (pending_attr_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_attr_q.size()));

		$display("Sent %0d escape bytes over %0d phases of idling and register settings,",
			n_bytes, NUM_PHASES + 1);
		$display("checked %0d accepted and %0d rejected sequences, %0d mismatches.",
			n_ok, n_rej, n_errors);
		if (n_errors == 0) begin
			$display("ansi_sgr_color_parser_top verification clean");
		end else begin
			$display("ansi_sgr_color_parser_top verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
